>>> hdl/r64enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r64enc_pkg
// Shared types and the character map for the radix-64 stream encoder.
// ----------------------------------------------------------------------------
package r64enc_pkg;

  localparam logic [6:0] PadChar   = 7'h3D;  // '='
  localparam logic [6:0] DashChar  = 7'h2D;  // '-'
  localparam logic [6:0] UnderChar = 7'h5F;  // '_'
  localparam logic [6:0] DigitBase = 7'h30;  // '0'
  localparam logic [6:0] UpperBase = 7'h41;  // 'A'
  localparam logic [6:0] LowerBase = 7'h61;  // 'a'

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       out_last;
  } out_t;

  // One finished group: 24-bit word, number of '=' pads, last flag.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  pads;
    logic        last;
  } group_t;

  function automatic logic [6:0] map_sextet(input logic [5:0] v);
    logic [6:0] c;
    if (v <= 6'd9) begin
      c = DigitBase + {1'b0, v};
    end else if (v <= 6'd35) begin
      c = UpperBase + ({1'b0, v} - 7'd10);
    end else if (v <= 6'd61) begin
      c = LowerBase + ({1'b0, v} - 7'd36);
    end else if (v == 6'd62) begin
      c = DashChar;
    end else begin
      c = UnderChar;
    end
    return c;
  endfunction

endpackage

>>> hdl/r64enc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r64enc_front
// Accepts bytes, collects them into groups of three and pushes each finished
// (or final partial) group into the queue.
// ----------------------------------------------------------------------------
module r64enc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  r64enc_pkg::in_t     in_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output r64enc_pkg::group_t  push_o
);

  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic [1:0] fill_q, fill_d;
  logic       xfer;

  assign in_ready_o = push_ready_i;
  assign xfer       = in_valid_i && in_ready_o;

  always_comb begin
    first_d      = first_q;
    second_d     = second_q;
    fill_d       = fill_q;
    push_valid_o = 1'b0;
    push_o.word  = {in_i.in_byte, 16'h0000};
    push_o.pads  = 2'd2;
    push_o.last  = 1'b1;
    unique case (fill_q)
      2'd1: begin
        push_o.word = {first_q, in_i.in_byte, 8'h00};
        push_o.pads = 2'd1;
        if (xfer) begin
          push_valid_o = in_i.in_last;
          second_d     = in_i.in_byte;
          fill_d       = in_i.in_last ? 2'd0 : 2'd2;
        end
      end
      2'd2: begin
        push_o.word = {first_q, second_q, in_i.in_byte};
        push_o.pads = 2'd0;
        push_o.last = in_i.in_last;
        if (xfer) begin
          push_valid_o = 1'b1;
          fill_d       = 2'd0;
        end
      end
      default: begin
        if (xfer) begin
          push_valid_o = in_i.in_last;
          first_d      = in_i.in_byte;
          fill_d       = in_i.in_last ? 2'd0 : 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

endmodule

>>> hdl/r64enc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r64enc_queue
// Two-entry group queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module r64enc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  r64enc_pkg::group_t  push_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output r64enc_pkg::group_t  pop_o
);

  r64enc_pkg::group_t mem_q [r64enc_pkg::QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'(r64enc_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_o        = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

>>> hdl/r64enc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r64enc_back
// Takes one group at a time from the queue and sends its four characters,
// one per transfer, with '=' padding and the last mark.
// ----------------------------------------------------------------------------
module r64enc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  r64enc_pkg::group_t  pop_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output r64enc_pkg::out_t    out_o
);

  r64enc_pkg::group_t grp_q;
  logic       act_q;
  logic [1:0] idx_q;
  logic [5:0] sextet;
  logic       is_pad;
  logic       done;

  assign out_valid_o = act_q;
  assign done        = act_q && out_ready_i && (idx_q == 2'd3);
  assign pop_ready_o = !act_q || done;

  always_comb begin
    unique case (idx_q)
      2'd0:    sextet = grp_q.word[23:18];
      2'd1:    sextet = grp_q.word[17:12];
      2'd2:    sextet = grp_q.word[11:6];
      default: sextet = grp_q.word[5:0];
    endcase
  end

  assign is_pad         = ({1'b0, idx_q} >= (3'd4 - {1'b0, grp_q.pads}));
  assign out_o.out_char = is_pad ? r64enc_pkg::PadChar : r64enc_pkg::map_sextet(sextet);
  assign out_o.out_last = grp_q.last && (idx_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      if (pop_ready_o) begin
        act_q <= pop_valid_i;
        idx_q <= 2'd0;
      end else if (out_ready_i) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) begin
      grp_q <= pop_i;
    end
  end

endmodule

>>> hdl/radix64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix64_stream_encoder
// Byte stream to radix-64 characters (0-9, A-Z, a-z, '-', '_'), '=' padded.
// ----------------------------------------------------------------------------
//  channel | ports                              | payload
//  --------+------------------------------------+--------------------------
//  in      | in_valid_i, in_ready_o, in_i       | in_byte[7:0], in_last
//  out     | out_valid_o, out_ready_i, out_o    | out_char[6:0], out_last
//
//  One byte per cycle is taken while the two-entry group queue has room.
//  The output port sends one character per cycle while out_ready_i is high,
//  so a full group of three bytes gives four characters.
//  A group's first character shows once it has passed the queue and grp_q.
//  Reset clears the byte fill count, queue pointers and output valid.
//  Output stalls back up through the queue to in_ready_o.
// ----------------------------------------------------------------------------
module radix64_stream_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  r64enc_pkg::in_t   in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output r64enc_pkg::out_t  out_o
);

  logic               push_valid, push_ready;
  logic               pop_valid, pop_ready;
  r64enc_pkg::group_t push_grp, pop_grp;

  r64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_o       (push_grp)
  );

  r64enc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push_grp),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_o        (pop_grp)
  );

  r64enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_i        (pop_grp),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

  // A last byte always closes a group.
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_i.in_last) |-> push_valid)
    else $error("last byte did not push a group");

  // No group is pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("group pushed into full queue");

  // A pad that is not the final character is followed by another character.
  a_pad_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.out_char == r64enc_pkg::PadChar) && !out_o.out_last)
      |=> out_valid_o)
    else $error("padding sequence broken");

  // Pad groups only occur on the final group of a message.
  a_pads_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && (push_grp.pads != 2'd0)) |-> push_grp.last)
    else $error("padded group not marked last");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test for radix64_stream_encoder: byte messages of assorted lengths
// go in, and every character that comes out is checked against a predicted
// radix-64 encoding with '=' padding and a last-character flag. Both sides
// stall at random, except during a steady stretch of the random run.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned StallPct   = 34;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandBytes  = 325;

  class char_scoreboard;
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;
    int unsigned       fill;
    r64enc_pkg::out_t  pending_chars[$];
    int unsigned       errors;

    function new();
      first_byte  = '0;
      second_byte = '0;
      fill        = 0;
      errors      = 0;
    endfunction

    function logic [6:0] sextet_char(input logic [5:0] s);
      logic [6:0] base;
      if (s == 6'd63) return r64enc_pkg::UnderChar;
      if (s == 6'd62) return r64enc_pkg::DashChar;
      if (s < 6'd10) base = r64enc_pkg::DigitBase;
      else if (s < 6'd36) base = r64enc_pkg::UpperBase - 7'd10;
      else base = r64enc_pkg::LowerBase - 7'd36;
      return base + {1'b0, s};
    endfunction

    // predicts the characters caused by one accepted byte
    function void note_byte(input r64enc_pkg::in_t t);
      logic [23:0]      word;
      int unsigned      pads;
      r64enc_pkg::out_t c;
      unique case (fill)
        0: begin
          if (!t.in_last) begin
            first_byte = t.in_byte;
            fill = 1;
            return;
          end
          word = {t.in_byte, 16'h0000};
          pads = 2;
        end
        1: begin
          if (!t.in_last) begin
            second_byte = t.in_byte;
            fill = 2;
            return;
          end
          word = {first_byte, t.in_byte, 8'h00};
          pads = 1;
        end
        default: begin
          word = {first_byte, second_byte, t.in_byte};
          pads = 0;
        end
      endcase
      fill = 0;
      for (int k = 0; k < 4; k++) begin
        c.out_char = (k >= 4 - pads) ? r64enc_pkg::PadChar
                                     : sextet_char(word[23 - 6 * k -: 6]);
        c.out_last = t.in_last && (k == 3);
        pending_chars.push_back(c);
      end
    endfunction

    task report(input string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_char(input r64enc_pkg::out_t got);
      r64enc_pkg::out_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected char %h last %b", got.out_char, got.out_last));
        return;
      end
      want = pending_chars.pop_front();
      if (got.out_char !== want.out_char)
        report($sformatf("char %h, expected %h", got.out_char, want.out_char));
      if (got.out_last !== want.out_last)
        report($sformatf("last %b, expected %b", got.out_last, want.out_last));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  r64enc_pkg::in_t  in_i        = '0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  r64enc_pkg::out_t out_o;
  logic             steady      = 1'b0;
  int unsigned idle_cycles = 0;

  char_scoreboard sb = new();

  radix64_stream_encoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(in_i);
      if (out_valid_o && out_ready_i) sb.check_char(out_o);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= StallLimit) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= StallPct);
  end

  // starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (!steady && $urandom_range(0, 99) < StallPct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_i.in_byte   <= b;
    in_i.in_last   <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_chars.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0]  msg[$];
    int unsigned sent;
    int unsigned len;
    bit          paused;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: lone bytes, two- and three-byte messages, full groups with tails
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'hFC});
    send_message('{8'hF8});
    send_message('{8'h00, 8'hFF});
    send_message('{8'hFF, 8'h00});
    send_message('{8'h00, 8'h00, 8'h00});
    send_message('{8'hFF, 8'hFF, 8'hFF});
    send_message('{8'h12, 8'h34, 8'h56, 8'h78});
    send_message('{8'hAB, 8'hCD, 8'hEF, 8'h01, 8'h23});

    sent   = 0;
    paused = 0;
    while (sent < RandBytes) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 9);
      msg.delete();
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      foreach (msg[i]) begin
        steady <= (sent >= 120 && sent < 220);
        if (!paused && sent >= 260) begin
          drain();
          paused = 1;
        end
        send_byte(msg[i], i == msg.size() - 1);
        sent++;
      end
    end

    steady <= 1'b0;
    drain();
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/r64enc_pkg.sv
hdl/r64enc_front.sv
hdl/r64enc_queue.sv
hdl/r64enc_back.sv
hdl/radix64_stream_encoder.sv
dv/tb.sv
